// ===== hw/rtl/dcc_pkg.sv =====
package dcc_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  // residues of the epoch year for the leap rule
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]  LAST_MOD100  = 7'd99;
  localparam logic [8:0]  LAST_MOD400  = 9'd399;
  localparam logic [8:0]  YEAR_LEN     = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
  localparam logic [3:0]  MONTH_FEB    = 4'd1;
  localparam logic [3:0]  MONTH_DEC    = 4'd11;

  typedef logic [1:0] step_t;
  localparam step_t STEP_LOAD  = 2'd0;
  localparam step_t STEP_YEAR  = 2'd1;
  localparam step_t STEP_MONTH = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  typedef enum logic [1:0] {
    COND_START      = 2'd0,
    COND_YEAR_DONE  = 2'd1,
    COND_MONTH_DONE = 2'd2,
    COND_OUT_FREE   = 2'd3
  } cond_e;

  // load and emit fire when the condition holds, the subtracts when it does not
  typedef struct packed {
    cond_e cond;
    step_t tgt_true;
    step_t tgt_false;
    logic  load;
    logic  sub_year;
    logic  sub_month;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic load;
    logic sub_year;
    logic sub_month;
  } dp_ctrl_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_stat_t;

  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '0;
    unique case (step)
      STEP_LOAD: begin
        w = '{cond: COND_START, tgt_true: STEP_YEAR, tgt_false: STEP_LOAD,
              load: 1'b1, sub_year: 1'b0, sub_month: 1'b0, emit: 1'b0};
      end
      STEP_YEAR: begin
        w = '{cond: COND_YEAR_DONE, tgt_true: STEP_MONTH, tgt_false: STEP_YEAR,
              load: 1'b0, sub_year: 1'b1, sub_month: 1'b0, emit: 1'b0};
      end
      STEP_MONTH: begin
        w = '{cond: COND_MONTH_DONE, tgt_true: STEP_EMIT, tgt_false: STEP_MONTH,
              load: 1'b0, sub_year: 1'b0, sub_month: 1'b1, emit: 1'b0};
      end
      STEP_EMIT: begin
        w = '{cond: COND_OUT_FREE, tgt_true: STEP_LOAD, tgt_false: STEP_EMIT,
              load: 1'b0, sub_year: 1'b0, sub_month: 1'b0, emit: 1'b1};
      end
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/dcc_datapath.sv =====
module dcc_datapath (
  input  logic               clk_i,
  input  dcc_pkg::dp_ctrl_t  ctrl_i,
  input  logic [5:0]         second_count_i,
  input  logic [5:0]         minute_count_i,
  input  logic [7:0]         hour_and_weekday_i,
  input  logic [15:0]        days_since_epoch_i,
  output dcc_pkg::dp_stat_t  stat_o,
  output logic [11:0]        year_value_o,
  output logic [3:0]         month_value_o,
  output logic [4:0]         day_of_month_value_o,
  output logic [4:0]         hour_value_o,
  output logic [2:0]         weekday_value_o,
  output logic [5:0]         minute_value_o,
  output logic [5:0]         second_value_o
);

  logic [15:0] rem_q, rem_d;
  logic [11:0] year_q, year_d;
  logic [1:0]  mod4_q, mod4_d;
  logic [6:0]  mod100_q, mod100_d;
  logic [8:0]  mod400_q, mod400_d;
  logic [3:0]  mon_q, mon_d;
  logic [5:0]  sec_q, min_q;
  logic [7:0]  hw_q;

  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;

  assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign ylen = leap ? dcc_pkg::LEAP_YEAR_LEN : dcc_pkg::YEAR_LEN;
  assign mlen = dcc_pkg::month_len(mon_q, leap);

  assign stat_o.year_done  = rem_q < {7'd0, ylen};
  assign stat_o.month_done = (mon_q == dcc_pkg::MONTH_DEC) || (rem_q < {11'd0, mlen});

  always_comb begin
    rem_d    = rem_q;
    year_d   = year_q;
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    mon_d    = mon_q;
    if (ctrl_i.load) begin
      rem_d    = days_since_epoch_i;
      year_d   = dcc_pkg::EPOCH_YEAR;
      mod4_d   = dcc_pkg::EPOCH_MOD4;
      mod100_d = dcc_pkg::EPOCH_MOD100;
      mod400_d = dcc_pkg::EPOCH_MOD400;
      mon_d    = 4'd0;
    end else if (ctrl_i.sub_year) begin
      rem_d    = rem_q - {7'd0, ylen};
      year_d   = year_q + 12'd1;
      mod4_d   = mod4_q + 2'd1;
      mod100_d = (mod100_q == dcc_pkg::LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
      mod400_d = (mod400_q == dcc_pkg::LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
    end else if (ctrl_i.sub_month) begin
      rem_d = rem_q - {11'd0, mlen};
      mon_d = mon_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    year_q   <= year_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    mon_q    <= mon_d;
    if (ctrl_i.load) begin
      sec_q <= second_count_i;
      min_q <= minute_count_i;
      hw_q  <= hour_and_weekday_i;
    end
  end

  assign year_value_o         = year_q;
  assign month_value_o        = mon_q + 4'd1;
  // day count left over is below 31 once the month walk stops
  assign day_of_month_value_o = rem_q[4:0] + 5'd1;
  assign hour_value_o         = hw_q[4:0];
  assign weekday_value_o      = hw_q[7:5];
  assign minute_value_o       = min_q;
  assign second_value_o       = sec_q;

endmodule

// ===== hw/rtl/day_count_to_calendar_date.sv =====
// Converts a real-time counter snapshot into a calendar date.
// Input stream (s_axis): one transfer carries seconds, minutes, the packed
// hour/weekday byte and a 16-bit count of days since 1970-01-01.
// Output stream (m_axis): one transfer per input with year, month, day of
// month, hour, weekday, minute and second.
// A small microcode program steps a shared subtract datapath: a load step,
// a year step that strips one whole year per pass until the final year
// check, a month step that strips one whole month per pass until the final
// month check, and a step to write the output register. The next input is
// taken in the cycle after the output register is written. The year walk
// dominates the conversion time.
// The output register holds its result while m_axis_tready_i is low; the
// next input can be converted meanwhile, and the program then waits in its
// final step until the register frees up.
// Reset clears the step counter and the output valid; the block is ready
// for input in the first cycle after reset.
module day_count_to_calendar_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // second_count[5:0], minute_count[11:6], hour_and_weekday[19:12],
  // days_since_epoch[35:20], zero fill
  input  logic [dcc_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // year_value[11:0], month_value[15:12], day_of_month_value[20:16],
  // hour_value[25:21], weekday_value[28:26], minute_value[34:29],
  // second_value[40:35], zero fill
  output logic [dcc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  dcc_pkg::step_t    step_q, step_d;
  dcc_pkg::uword_t   uword;
  dcc_pkg::dp_ctrl_t dp_ctrl;
  dcc_pkg::dp_stat_t dp_stat;
  logic              cond_true;
  logic              emit;
  logic              m_valid_q;
  logic [40:0]       m_data_q;

  logic [11:0] year_value;
  logic [3:0]  month_value;
  logic [4:0]  day_of_month_value;
  logic [4:0]  hour_value;
  logic [2:0]  weekday_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;

  assign uword = dcc_pkg::ucode_rom(step_q);

  always_comb begin
    unique case (uword.cond)
      dcc_pkg::COND_START:      cond_true = s_axis_tvalid_i;
      dcc_pkg::COND_YEAR_DONE:  cond_true = dp_stat.year_done;
      dcc_pkg::COND_MONTH_DONE: cond_true = dp_stat.month_done;
      dcc_pkg::COND_OUT_FREE:   cond_true = !m_valid_q || m_axis_tready_i;
    endcase
  end

  assign step_d            = cond_true ? uword.tgt_true : uword.tgt_false;
  assign dp_ctrl.load      = uword.load && cond_true;
  assign dp_ctrl.sub_year  = uword.sub_year && !cond_true;
  assign dp_ctrl.sub_month = uword.sub_month && !cond_true;
  assign emit              = uword.emit && cond_true;

  assign s_axis_tready_o = uword.load;

  dcc_datapath u_datapath (
    .clk_i                (clk_i),
    .ctrl_i               (dp_ctrl),
    .second_count_i       (s_axis_tdata_i[5:0]),
    .minute_count_i       (s_axis_tdata_i[11:6]),
    .hour_and_weekday_i   (s_axis_tdata_i[19:12]),
    .days_since_epoch_i   (s_axis_tdata_i[35:20]),
    .stat_o               (dp_stat),
    .year_value_o         (year_value),
    .month_value_o        (month_value),
    .day_of_month_value_o (day_of_month_value),
    .hour_value_o         (hour_value),
    .weekday_value_o      (weekday_value),
    .minute_value_o       (minute_value),
    .second_value_o       (second_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= dcc_pkg::STEP_LOAD;
      m_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {second_value, minute_value, weekday_value, hour_value,
                   day_of_month_value, month_value, year_value};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(dcc_pkg::OutDataW - 41){1'b0}}, m_data_q};

  a_load_starts_year_walk : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (step_q == dcc_pkg::STEP_YEAR)
  ) else $error("input transfer did not start the year walk");

  a_emit_needs_free_slot : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_valid_q || m_axis_tready_i)
  ) else $error("output register overwritten while a result waits");

  a_date_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[15:12] != 4'd0) && (m_data_q[15:12] <= 4'd12)
                  && (m_data_q[20:16] != 5'd0)
  ) else $error("emitted month or day out of range");

  a_no_input_while_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (step_q != dcc_pkg::STEP_LOAD) |-> !s_axis_tready_o
  ) else $error("input taken during a conversion");

endmodule

// ===== tb/day_count_to_calendar_date_tb.sv =====
module day_count_to_calendar_date_tb;

  localparam int unsigned FirstYear  = 1970;
  localparam int unsigned RandItems  = 2000;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned TailCycles = 250;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [7:0]  hour_wd;
    logic [15:0] days;
    bit          drain_first;
  } snapshot_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [dcc_pkg::InDataW-1:0]  s_data = '0;
  logic                         m_valid;
  logic                         m_ready = 1'b0;
  logic [dcc_pkg::OutDataW-1:0] m_data;

  snapshot_t   snapshot_queue[$];
  date_t       pending_dates[$];
  snapshot_t   in_flight;
  int unsigned total_items;
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned unexpected_count = 0;
  int unsigned cycle_count = 0;

  day_count_to_calendar_date u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // walk whole years, then whole months, off the day count
  function automatic date_t calendar_of(input snapshot_t s);
    date_t       d;
    int unsigned left;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    left = s.days;
    yr   = FirstYear;
    len  = is_leap(yr) ? 366 : 365;
    while (left >= len) begin
      left -= len;
      yr++;
      len = is_leap(yr) ? 366 : 365;
    end
    mon = 0;
    while (mon < 11) begin
      case (mon)
        1:          len = is_leap(yr) ? 29 : 28;
        3, 5, 8, 10: len = 30;
        default:    len = 31;
      endcase
      if (left < len) break;
      left -= len;
      mon++;
    end
    d.year   = 12'(yr);
    d.month  = 4'(mon + 1);
    d.mday   = 5'(left + 1);
    d.hour   = s.hour_wd[4:0];
    d.wday   = s.hour_wd[7:5];
    d.minute = s.minute;
    d.second = s.second;
    return d;
  endfunction

  function automatic snapshot_t make_snapshot(input int unsigned sec, input int unsigned min,
                                              input int unsigned hw, input int unsigned days,
                                              input bit drain);
    snapshot_t s;
    s.second      = 6'(sec);
    s.minute      = 6'(min);
    s.hour_wd     = 8'(hw);
    s.days        = 16'(days);
    s.drain_first = drain;
    return s;
  endfunction

  // sender idles 37% then 64% then never; receiver the other way round
  function automatic int unsigned idle_pct(input bit sender);
    int unsigned phase;
    phase = (total_items == 0) ? 0 : (sent_count * 3) / total_items;
    case (phase)
      0:       return sender ? 37 : 64;
      1:       return sender ? 64 : 37;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    snapshot_t nxt;
    logic      fire;
    logic      go;
    if (rst_ni) begin
      fire = s_valid && s_ready;
      if (fire) begin
        pending_dates.push_back(calendar_of(in_flight));
        sent_count++;
      end
      if (!s_valid || fire) begin
        go = 1'b0;
        if (snapshot_queue.size() > 0) begin
          nxt = snapshot_queue[0];
          if (nxt.drain_first && (got_count != sent_count)) go = 1'b0;
          else go = ($urandom_range(99) >= idle_pct(1'b1));
        end
        if (go) begin
          void'(snapshot_queue.pop_front());
          in_flight = nxt;
          s_data <= {4'b0, nxt.days, nxt.hour_wd, nxt.minute, nxt.second};
        end
        s_valid <= go;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    date_t got;
    date_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got.year   = m_data[11:0];
        got.month  = m_data[15:12];
        got.mday   = m_data[20:16];
        got.hour   = m_data[25:21];
        got.wday   = m_data[28:26];
        got.minute = m_data[34:29];
        got.second = m_data[40:35];
        if (pending_dates.size() == 0) begin
          unexpected_count++;
          if (mismatch_count + unexpected_count <= MaxReports)
            $display("unexpected date transfer %0d-%0d-%0d", got.year, got.month, got.mday);
        end else begin
          want = pending_dates.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= MaxReports)
              $display("date mismatch: exp %0d-%0d-%0d %0d:%0d:%0d wd %0d,",
                       want.year, want.month, want.mday, want.hour, want.minute,
                       want.second, want.wday,
                       " got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                       got.year, got.month, got.mday, got.hour, got.minute,
                       got.second, got.wday);
          end
        end
        got_count <= got_count + 1;
      end
      m_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned sec;
    int unsigned min;
    int unsigned days;
    int unsigned pick;
    // field extremes, epoch, month ends, leap days, century rules, last count
    snapshot_queue.push_back(make_snapshot(0, 0, 8'h00, 0, 1'b0));
    snapshot_queue.push_back(make_snapshot(63, 63, 8'hff, 65535, 1'b0));
    snapshot_queue.push_back(make_snapshot(59, 59, 8'hf7, 30, 1'b0));
    snapshot_queue.push_back(make_snapshot(60, 60, 8'h1f, 31, 1'b0));
    snapshot_queue.push_back(make_snapshot(1, 2, 8'he0, 58, 1'b0));
    snapshot_queue.push_back(make_snapshot(3, 4, 8'h20, 59, 1'b0));
    snapshot_queue.push_back(make_snapshot(5, 6, 8'h37, 364, 1'b0));
    snapshot_queue.push_back(make_snapshot(7, 8, 8'h41, 365, 1'b0));
    snapshot_queue.push_back(make_snapshot(9, 10, 8'h5c, 789, 1'b0));
    snapshot_queue.push_back(make_snapshot(11, 12, 8'h77, 790, 1'b0));
    snapshot_queue.push_back(make_snapshot(13, 14, 8'h8a, 1095, 1'b0));
    snapshot_queue.push_back(make_snapshot(15, 16, 8'h98, 10957, 1'b0));
    snapshot_queue.push_back(make_snapshot(17, 18, 8'hb3, 11016, 1'b0));
    snapshot_queue.push_back(make_snapshot(19, 20, 8'hc7, 11017, 1'b0));
    snapshot_queue.push_back(make_snapshot(21, 22, 8'hd0, 11322, 1'b0));
    snapshot_queue.push_back(make_snapshot(23, 24, 8'hf0, 11323, 1'b0));
    snapshot_queue.push_back(make_snapshot(25, 26, 8'h2e, 47481, 1'b0));
    snapshot_queue.push_back(make_snapshot(27, 28, 8'h4f, 47540, 1'b0));
    snapshot_queue.push_back(make_snapshot(29, 30, 8'h63, 47541, 1'b0));
    snapshot_queue.push_back(make_snapshot(31, 32, 8'h85, 65534, 1'b0));
    for (int unsigned i = 0; i < RandItems; i++) begin
      sec  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
      min  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
      pick = $urandom_range(9);
      if (pick < 2) begin
        days = $urandom_range(1500);
      end else if (pick < 4) begin
        // close to a new year
        days = ($urandom_range(179) * 36525) / 100 + $urandom_range(4);
        days = (days >= 2) ? days - 2 : days;
        if (days > 65535) days = 65535;
      end else begin
        days = $urandom_range(65535);
      end
      snapshot_queue.push_back(make_snapshot(sec, min, $urandom_range(255), days,
                                             (i == RandItems / 2) || (i == RandItems / 5)));
    end
    total_items = snapshot_queue.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (snapshot_queue.size() > 0 || s_valid) @(posedge clk_i);
    while (got_count != sent_count) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d snapshots sent across three handshake phases, %0d dates checked",
             sent_count, got_count);
    $display("%0d mismatches, %0d unexpected transfers, %0d dates still owed",
             mismatch_count, unexpected_count, pending_dates.size());
    if (mismatch_count == 0 && unexpected_count == 0 && pending_dates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_datapath.sv
hw/rtl/day_count_to_calendar_date.sv
tb/day_count_to_calendar_date_tb.sv
